// File: rtl/pls_pkg.sv
// pls_pkg: shared types and constants for the positional list store
// depends on nothing; imported by pls_ctrl and positional_list_store

package pls_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = ADDR_W + 1;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;

  typedef enum logic [2:0] {
    ACT_CLEAR    = 3'd0,
    ACT_INSERT   = 3'd1,
    ACT_DELETE   = 3'd2,
    ACT_LOCATE   = 3'd3,
    ACT_RETRIEVE = 3'd4,
    ACT_FIRST    = 3'd5,
    ACT_LAST     = 3'd6,
    ACT_NEXT     = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS,
    S_DEL,
    S_LOC,
    S_RDWAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  value;
    logic [POS_W-1:0]          found_position;
  } res_t;

endpackage

// File: rtl/positional_list_store.sv
// positional_list_store: bounded ordered list of signed 32-bit values with 1-based positions
// depends on pls_pkg and pls_ctrl (which holds pls_ram)
//
//  channel  handshake            payload
//  in       in_valid / in_ready  action, value, position
//  out      out_valid / out_ready status, item_value, found_position
//
// after accept the controller runs S_START and then S_FINISH for clear and refused items;
// reads pass S_RDWAIT, and insert, delete and locate pass S_INS, S_DEL or S_LOC first;
// those move or scan one entry per cycle; a locate that misses in a full list scans all 64
// the entry memory does one read and one write a cycle; S_FINISH holds until the output is free
// reset empties the list; entry contents are not cleared
// a finished item waits in the output register while the next item is accepted

module positional_list_store import pls_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               action,
  input  logic signed [DATA_W-1:0] value,
  input  logic [POS_W-1:0]         position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] item_value,
  output logic [POS_W-1:0]         found_position
);

  logic             slot_free;
  logic             done;
  res_t             res;
  logic [LEN_W-1:0] len;

  assign slot_free = !out_valid || out_ready;

  pls_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (in_valid && in_ready),
    .in_action   (action),
    .in_value    (value),
    .in_position (position),
    .slot_free   (slot_free),
    .idle        (in_ready),
    .done        (done),
    .res         (res),
    .len         (len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && slot_free) begin
      status         <= res.status;
      item_value     <= res.value;
      found_position <= res.found_position;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accept");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    done && res.status == ST_FULL |-> len == LEN_W'(CAPACITY))
    else $error("full status with room left");

  a_found_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> found_position == '0 || status == ST_OK)
    else $error("found position inconsistent with status");

endmodule

// File: rtl/pls_ram.sv
// pls_ram: single write port, single registered read port memory
// depends on nothing

module pls_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pls_ctrl.sv
// pls_ctrl: sequencer that shifts, scans and reads the entry memory one entry a cycle
// depends on pls_pkg and pls_ram

module pls_ctrl import pls_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2:0]               in_action,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  input  logic                     slot_free,
  output logic                     idle,
  output logic                     done,
  output res_t                     res,
  output logic [LEN_W-1:0]         len
);

  state_t                   state, state_next;
  logic [LEN_W-1:0]         len_next;
  action_t                  op, op_next;
  logic signed [DATA_W-1:0] val, val_next;
  logic [POS_W-1:0]         pos, pos_next;
  logic [LEN_W-1:0]         cnt, cnt_next;
  logic                     pend, pend_next;
  logic [LEN_W-1:0]         pend_idx, pend_idx_next;
  res_t                     res_next;

  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic [DATA_W-1:0]        wdata;
  logic [ADDR_W-1:0]        raddr;
  logic [DATA_W-1:0]        rdata;
  logic [POS_W:0]           pos_x;
  logic [POS_W:0]           len_x;

  pls_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pos_x = {1'b0, pos};
  assign len_x = (POS_W + 1)'(len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    val      <= val_next;
    pos      <= pos_next;
    cnt      <= cnt_next;
    pend_idx <= pend_idx_next;
    res      <= res_next;
  end

  always_comb begin
    state_next    = state;
    len_next      = len;
    op_next       = op;
    val_next      = val;
    pos_next      = pos;
    cnt_next      = cnt;
    pend_next     = 1'b0;
    pend_idx_next = pend_idx;
    res_next      = res;
    we            = 1'b0;
    waddr         = pend_idx[ADDR_W-1:0];
    wdata         = rdata;
    raddr         = cnt[ADDR_W-1:0];
    idle          = (state == S_IDLE);
    done          = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next    = action_t'(in_action);
          val_next   = in_value;
          pos_next   = in_position;
          state_next = S_START;
        end
      end

      S_START: begin
        res_next   = '{status: ST_OK, value: '0, found_position: '0};
        state_next = S_FINISH;
        case (op)
          ACT_CLEAR: begin
            len_next = '0;
          end
          ACT_INSERT: begin
            if (pos == '0 || pos_x > len_x + 1'b1) begin
              res_next.status = ST_INVALID;
            end else if (len == LEN_W'(CAPACITY)) begin
              res_next.status = ST_FULL;
            end else begin
              cnt_next   = len;
              state_next = S_INS;
            end
          end
          ACT_DELETE: begin
            if (pos == '0 || pos_x > len_x) begin
              res_next.status = ST_INVALID;
            end else begin
              cnt_next   = LEN_W'(pos);
              state_next = S_DEL;
            end
          end
          ACT_LOCATE: begin
            cnt_next   = '0;
            state_next = S_LOC;
          end
          ACT_RETRIEVE: begin
            raddr = ADDR_W'(pos - 1'b1);
            if (pos == '0 || pos_x > len_x) begin
              res_next.status = ST_INVALID;
            end else begin
              state_next = S_RDWAIT;
            end
          end
          ACT_FIRST: begin
            raddr = '0;
            if (len == '0) begin
              res_next.status = ST_INVALID;
            end else begin
              state_next = S_RDWAIT;
            end
          end
          ACT_LAST: begin
            raddr = ADDR_W'(len - 1'b1);
            if (len == '0) begin
              res_next.status = ST_INVALID;
            end else begin
              state_next = S_RDWAIT;
            end
          end
          default: begin
            raddr = ADDR_W'(pos);
            if (pos == '0 || pos_x >= len_x) begin
              res_next.status = ST_INVALID;
            end else begin
              state_next = S_RDWAIT;
            end
          end
        endcase
      end

      // shift entries pos-1..len-1 up by one, last entry first
      S_INS: begin
        if (cnt >= LEN_W'(pos)) begin
          raddr         = ADDR_W'(cnt - 1'b1);
          cnt_next      = cnt - 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = cnt;
        end
        if (pend) begin
          we = 1'b1;
        end else if (cnt < LEN_W'(pos)) begin
          we         = 1'b1;
          waddr      = ADDR_W'(pos - 1'b1);
          wdata      = val;
          len_next   = len + 1'b1;
          state_next = S_FINISH;
        end
      end

      // shift entries pos..len-1 down by one, first entry first
      S_DEL: begin
        if (cnt < len) begin
          raddr         = cnt[ADDR_W-1:0];
          cnt_next      = cnt + 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = cnt - 1'b1;
        end
        if (pend) begin
          we = 1'b1;
        end else if (cnt >= len) begin
          len_next   = len - 1'b1;
          state_next = S_FINISH;
        end
      end

      S_LOC: begin
        if (pend && rdata == val) begin
          res_next.found_position = POS_W'(pend_idx);
          state_next              = S_FINISH;
        end else if (cnt < len) begin
          raddr         = cnt[ADDR_W-1:0];
          cnt_next      = cnt + 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = cnt + 1'b1;
        end else if (!pend) begin
          res_next.status = ST_INVALID;
          state_next      = S_FINISH;
        end
      end

      S_RDWAIT: begin
        res_next.value = rdata;
        state_next     = S_FINISH;
      end

      S_FINISH: begin
        done = 1'b1;
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
